### hdl/sts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sts_pkg: shared definitions for the sorted table binary search
// Widths, codes, the sequencer state type and the structs that pass
// between the top level and the search core.
// ---------------------------------------------------------------------------
package sts_pkg;

	localparam int DEPTH_DEFAULT = 1024;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 10;
	localparam int SIZE_W = 11;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Operation codes carried by op.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Register index, taken from paddr[2].
	localparam logic REG_TABLE_SIZE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic                     start;
		logic                     op;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] search_key;
	} cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             found;
		logic [IDX_W-1:0] position;
	} result_t;

endpackage
`default_nettype wire

### hdl/sts_search_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sts_search_core: entry table memory and binary search sequencer
// Holds the table in a synchronous memory and probes it one entry per
// cycle, with both candidate midpoints prepared ahead of each compare.
// ---------------------------------------------------------------------------
module sts_search_core
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SIZE_W-1:0] table_size,
	input  wire cmd_t              cmd,
	output result_t                res
);

	localparam int AW = $clog2(DEPTH);
	// Signed span for lo, hi and their sums; hi may reach -1.
	localparam int W  = AW + 2;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	state_t state_q, state_d;

	logic signed [W-1:0] lo_q, lo_d;
	logic signed [W-1:0] hi_q, hi_d;
	logic [AW-1:0]       mid_q, mid_d;
	logic signed [DATA_W-1:0] key_q;

	logic done_q, found_q;
	logic [IDX_W-1:0] position_q;

	logic finish, hit;
	logic rd_en;
	logic wr_en;
	logic accept;

	logic [31:0]         idx_ext;
	logic [31:0]         size_ext;
	logic [31:0]         n_sat;
	logic [31:0]         mid_ext;
	logic signed [W-1:0] mid_w, lo_up, hi_dn, cand_up, cand_dn, cand_first;
	logic                empty_up, empty_dn;
	logic signed [W-1:0] sum_up, sum_dn, sum_first;

	assign accept  = cmd.start && (state_q == ST_IDLE);
	assign idx_ext = 32'(cmd.entry_index);
	assign wr_en   = accept && (cmd.op == OP_WRITE) && (idx_ext < 32'(DEPTH));

	assign size_ext = 32'(table_size);
	assign n_sat    = (size_ext > 32'(DEPTH)) ? 32'(DEPTH) : size_ext;

	// Candidate midpoints for both compare outcomes.
	assign mid_w      = signed'({2'b00, mid_q});
	assign lo_up      = mid_w + W'(1);
	assign hi_dn      = mid_w - W'(1);
	assign sum_up     = lo_up + hi_q;
	assign sum_dn     = lo_q + hi_dn;
	assign sum_first  = lo_q + hi_q;
	assign cand_up    = sum_up >>> 1;
	assign cand_dn    = sum_dn >>> 1;
	assign cand_first = sum_first >>> 1;
	assign empty_up   = lo_up > hi_q;
	assign empty_dn   = lo_q > hi_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		if (accept) begin
			key_q <= cmd.search_key;
		end
		if (finish) begin
			found_q    <= hit;
			position_q <= hit ? mid_ext[IDX_W-1:0] : '0;
		end
	end

	assign mid_ext = 32'(mid_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_ext[AW-1:0]] <= cmd.entry_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[mid_d];
		end
	end

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		rd_en   = 1'b0;
		finish  = 1'b0;
		hit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.op == OP_SEARCH)) begin
					lo_d    = '0;
					hi_d    = W'(n_sat) - W'(1);
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (lo_q > hi_q) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					mid_d   = cand_first[AW-1:0];
					rd_en   = 1'b1;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (rd_data_q == key_q) begin
					finish  = 1'b1;
					hit     = 1'b1;
					state_d = ST_IDLE;
				end else if (rd_data_q < key_q) begin
					lo_d = lo_up;
					if (empty_up) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						mid_d = cand_up[AW-1:0];
						rd_en = 1'b1;
					end
				end else begin
					hi_d = hi_dn;
					if (empty_dn) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						mid_d = cand_dn[AW-1:0];
						rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.busy     = (state_q != ST_IDLE);
	assign res.done     = done_q;
	assign res.found    = found_q;
	assign res.position = position_q;

endmodule
`default_nettype wire

### hdl/sorted_table_binary_search.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a loaded sorted table
// Software loads signed 32-bit entries in ascending order with write
// commands, sets table_size over the APB port, and issues search commands.
// ---------------------------------------------------------------------------
//
//   Channel   Signals                                      Transfer when
//   -------   -------------------------------------------  ----------------------
//   command   start, busy, op, entry_index, entry_value,   start high, busy low
//             search_key
//   result    done, found, position                        done high (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata,         psel, penable, pwrite,
//             prdata, pready                               pready all high
//
// A write command is taken while busy is low and leaves busy low, so the next
// command can follow at once. A search holds busy through the ST_FIRST setup
// state and then through ST_PROBE, which probes the table memory one entry per
// cycle; done rises in the same cycle that busy falls. The probe rate is set
// by the single read port of the table memory, whose registered data feeds
// the key compare. Reset clears the sequencer and table_size; the table
// itself is undefined until written. The result receiver cannot stall: done
// marks each result for exactly one cycle.
//
module sorted_table_binary_search
	import sts_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Configuration port.
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output      logic [APB_DW-1:0]        prdata,
	output      logic                     pready,
	// Command channel.
	input  wire logic                     start,
	output      logic                     busy,
	input  wire logic                     op,
	input  wire logic [IDX_W-1:0]         entry_index,
	input  wire logic signed [DATA_W-1:0] entry_value,
	input  wire logic signed [DATA_W-1:0] search_key,
	// Result channel.
	output      logic                     done,
	output      logic                     found,
	output      logic [IDX_W-1:0]         position
);

	logic [SIZE_W-1:0] table_size_q;
	logic              cfg_write;
	logic              reg_index;
	cmd_t              cmd;
	result_t           res;

	// The register index is the word address; byte lane bits are ignored.
	assign reg_index = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (cfg_write && (reg_index == REG_TABLE_SIZE)) begin
			table_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	// Reads of the unused address return zero.
	assign prdata = (reg_index == REG_TABLE_SIZE) ? APB_DW'(table_size_q) : '0;

	assign cmd.start       = start;
	assign cmd.op          = op;
	assign cmd.entry_index = entry_index;
	assign cmd.entry_value = entry_value;
	assign cmd.search_key  = search_key;

	sts_search_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.table_size(table_size_q),
		.cmd       (cmd),
		.res       (res)
	);

	assign busy     = res.busy;
	assign done     = res.done;
	assign found    = res.found;
	assign position = res.position;

endmodule
`default_nettype wire
